>>> src/bfsam_pkg.sv
// Shared types and constants for the breadth-first adjacency-matrix walk.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfsam_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int LABEL_BITS_DEF   = 32;
  localparam int COUNT_W          = 5;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 5'd16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  localparam logic STATUS_VISITED   = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic srch_inc;
    logic root_from_sidx;
    logic root_from_r;
    logic restart_step;
    logic set_child;
    logic scan_step;
    logic disc;
    logic emit;
    logic emit_err;
    logic deq;
    logic latch_u;
    logic latch_row;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sidx_end;
    logic label_match;
    logic all_found;
    logic scan_end;
    logic child_hit;
    logic queue_empty;
    logic restart_end;
    logic restart_hit;
    logic cur_root;
  } stat_t;

endpackage

>>> src/bfs_adjacency_matrix_walk.sv
// Top level of the breadth-first adjacency-matrix walk: configuration port
// and the controller/datapath pair. Depends on bfsam_pkg, bfsam_ctrl, bfsam_dp.
//
// Usage. An item is taken at a rising edge where start is high and busy is
// low. A load (action = 0) writes one adjacency row and label for vertex_index
// and busy stays low. A run (action = 1) starts from the lowest vertex whose
// label equals source_label; busy stays high until it ends. Each result is a
// one-cycle transfer marked by result_valid; the receiver cannot stall. An
// absent label gives one transfer with status and last set; otherwise every
// vertex in use is reported once, in discovery order, with last set on the
// final one. The label search reads and compares each vertex in turn; a miss
// ends with a read that finds the search done, then the error state. A
// discovery passes a label read and a result register state. A queue pop
// passes the dequeue, queue-wait and row-wait states, then scans each column
// of its row and closes the row with a further scan state; an empty queue and
// each vertex checked for a restart take a state apiece. The last strobe of
// a run comes in the same cycle as busy falls. Reset clears the walk state and
// sets vertex_count to 16; row and label memories are undefined until loaded.
// vertex_count is written at byte address 0 of the configuration port; write
// it only while the block is idle; the block itself does not enforce this.
module bfs_adjacency_matrix_walk #(
  parameter int MAX_VERTICES = bfsam_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = bfsam_pkg::LABEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Item channel
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [3:0]         vertex_index,
  input  logic [15:0]        adjacency_row,
  input  logic signed [31:0] vertex_label,
  input  logic signed [31:0] source_label,
  // Result channel
  output logic               result_valid,
  output logic               status,
  output logic [3:0]         visited_index,
  output logic signed [31:0] visited_label,
  output logic [3:0]         distance,
  output logic               has_predecessor,
  output logic [3:0]         predecessor_index,
  output logic               new_tree,
  output logic               last,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bfsam_pkg::cmd_t  cmd;
  bfsam_pkg::stat_t stat;
  logic [bfsam_pkg::COUNT_W-1:0] vertex_count;
  logic reg_hit;

  // Register index is the word address; only vertex_count exists.
  assign reg_hit = (paddr[2] == bfsam_pkg::REG_VERTEX_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(vertex_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= bfsam_pkg::VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      vertex_count <= pwdata[bfsam_pkg::COUNT_W-1:0];
    end
  end

  bfsam_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  bfsam_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .LABEL_BITS   (LABEL_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .vertex_count      (vertex_count),
    .vertex_index      (vertex_index),
    .adjacency_row     (adjacency_row),
    .vertex_label      (vertex_label),
    .source_label      (source_label),
    .result_valid      (result_valid),
    .status            (status),
    .visited_index     (visited_index),
    .visited_label     (visited_label),
    .distance          (distance),
    .has_predecessor   (has_predecessor),
    .predecessor_index (predecessor_index),
    .new_tree          (new_tree),
    .last              (last)
  );

endmodule

>>> src/bfsam_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the adjacency rows, the labels and the pending queue.
module bfsam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bfsam_ctrl.sv
// Sequencer for the breadth-first walk: label search, discovery, queue pops,
// row scans and forest restarts. Depends on bfsam_pkg for the command types.
module bfsam_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             action,
  input  bfsam_pkg::stat_t stat,
  output bfsam_pkg::cmd_t  cmd,
  output logic             busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_ERR,
    S_DISC,
    S_EMIT,
    S_SCAN,
    S_DEQ,
    S_DEQ_WAIT,
    S_ROW_WAIT,
    S_RESTART
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          if (action == bfsam_pkg::ACT_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.init   = 1'b1;
            state_next = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        // The label read at the search index is issued here.
        state_next = stat.sidx_end ? S_ERR : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat.label_match) begin
          cmd.root_from_sidx = 1'b1;
          state_next         = S_DISC;
        end else begin
          cmd.srch_inc = 1'b1;
          state_next   = S_SRCH_RD;
        end
      end
      S_ERR: begin
        cmd.emit_err = 1'b1;
        state_next   = S_IDLE;
      end
      S_DISC: begin
        cmd.disc   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.all_found) begin
          state_next = S_IDLE;
        end else if (stat.cur_root) begin
          state_next = S_DEQ;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_next = S_DEQ;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.child_hit) begin
            cmd.set_child = 1'b1;
            state_next    = S_DISC;
          end
        end
      end
      S_DEQ: begin
        if (stat.queue_empty) begin
          state_next = S_RESTART;
        end else begin
          cmd.deq    = 1'b1;
          state_next = S_DEQ_WAIT;
        end
      end
      S_DEQ_WAIT: begin
        cmd.latch_u = 1'b1;
        state_next  = S_ROW_WAIT;
      end
      S_ROW_WAIT: begin
        cmd.latch_row = 1'b1;
        state_next    = S_SCAN;
      end
      S_RESTART: begin
        if (stat.restart_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.restart_step = 1'b1;
          if (stat.restart_hit) begin
            cmd.root_from_r = 1'b1;
            state_next      = S_DISC;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

`ifndef SYNTHESIS
  ap_emit_single: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> (state != S_EMIT))
    else $error("two discovery results in consecutive cycles");

  ap_busy_tracks_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy disagrees with the sequencer state");

  ap_err_ends_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERR) |=> (state == S_IDLE))
    else $error("run continued after a label miss");
`endif

endmodule

>>> src/bfsam_dp.sv
// Datapath of the breadth-first walk: row, label and queue memories, visit
// flags, counters and the result register. Depends on bfsam_pkg and bfsam_ram.
module bfsam_dp #(
  parameter int MAX_VERTICES = bfsam_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = bfsam_pkg::LABEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bfsam_pkg::cmd_t                  cmd,
  output bfsam_pkg::stat_t                 stat,
  input  logic [bfsam_pkg::COUNT_W-1:0]    vertex_count,
  input  logic [3:0]                       vertex_index,
  input  logic [15:0]                      adjacency_row,
  input  logic signed [31:0]               vertex_label,
  input  logic signed [31:0]               source_label,
  output logic                             result_valid,
  output logic                             status,
  output logic [3:0]                       visited_index,
  output logic signed [31:0]               visited_label,
  output logic [3:0]                       distance,
  output logic                             has_predecessor,
  output logic [3:0]                       predecessor_index,
  output logic                             new_tree,
  output logic                             last
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [7:0] MAX8 = 8'(MAX_VERTICES);

  logic [7:0]      vc_ext;
  logic [CW-1:0]   n;
  logic [CW-1:0]   sidx, jdx, rdx, head, tail, count;
  logic [VW-1:0]   cur, cur_pred, u;
  logic [VW-1:0]   cur_dist, du;
  logic            cur_root;
  logic [LABEL_BITS-1:0] want;
  logic [MAX_VERTICES-1:0] visited, row;

  logic            load_ok;
  logic [VW-1:0]   load_addr;
  logic [VW-1:0]   label_raddr;
  logic [LABEL_BITS-1:0] label_rdata;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [2*VW-1:0] q_wdata, q_rdata;
  logic [VW-1:0]   q_vert, q_dist;
  logic [7:0]      dist_ext;

  assign vc_ext    = 8'(vertex_count);
  assign n         = (vc_ext > MAX8) ? CW'(MAX8) : CW'(vc_ext);
  assign load_ok   = cmd.load && (8'(vertex_index) < MAX8);
  assign load_addr = VW'(vertex_index);
  assign label_raddr = cmd.disc ? cur : sidx[VW-1:0];
  assign q_wdata   = {cur_dist, cur};
  assign q_vert    = q_rdata[VW-1:0];
  assign q_dist    = q_rdata[2*VW-1:VW];

  bfsam_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_addr),
    .wdata (MAX_VERTICES'(adjacency_row)),
    .raddr (q_vert),
    .rdata (adj_rdata)
  );

  bfsam_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_VERTICES)) u_label_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_addr),
    .wdata (LABEL_BITS'(vertex_label)),
    .raddr (label_raddr),
    .rdata (label_rdata)
  );

  bfsam_ram #(.WIDTH(2*VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
    .clk   (clk),
    .we    (cmd.disc),
    .waddr (tail[VW-1:0]),
    .wdata (q_wdata),
    .raddr (head[VW-1:0]),
    .rdata (q_rdata)
  );

  always_comb begin
    stat             = '0;
    stat.sidx_end    = (sidx == n);
    stat.label_match = (label_rdata == want);
    stat.all_found   = (count == n);
    stat.scan_end    = (jdx == n);
    stat.child_hit   = row[jdx[VW-1:0]] && !visited[jdx[VW-1:0]];
    stat.queue_empty = (head == tail);
    stat.restart_end = (rdx == n);
    stat.restart_hit = !visited[rdx[VW-1:0]];
    stat.cur_root    = cur_root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sidx    <= '0;
      jdx     <= '0;
      rdx     <= '0;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      visited <= '0;
    end else begin
      if (cmd.init) begin
        sidx    <= '0;
        rdx     <= '0;
        head    <= '0;
        tail    <= '0;
        count   <= '0;
        visited <= '0;
      end
      if (cmd.srch_inc) begin
        sidx <= sidx + CW'(1);
      end
      if (cmd.restart_step) begin
        rdx <= rdx + CW'(1);
      end
      if (cmd.scan_step) begin
        jdx <= jdx + CW'(1);
      end
      if (cmd.latch_row) begin
        jdx <= '0;
      end
      if (cmd.disc) begin
        visited[cur] <= 1'b1;
        tail         <= tail + CW'(1);
        count        <= count + CW'(1);
      end
      if (cmd.deq) begin
        head <= head + CW'(1);
      end
    end
  end

  // Payload registers: search label, current vertex with its distance and parent, the popped vertex and row.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      want <= LABEL_BITS'(source_label);
    end
    if (cmd.root_from_sidx || cmd.root_from_r) begin
      cur      <= cmd.root_from_r ? rdx[VW-1:0] : sidx[VW-1:0];
      cur_dist <= '0;
      cur_pred <= '0;
      cur_root <= 1'b1;
    end
    if (cmd.set_child) begin
      cur      <= jdx[VW-1:0];
      cur_dist <= du + VW'(1);
      cur_pred <= u;
      cur_root <= 1'b0;
    end
    if (cmd.latch_u) begin
      u  <= q_vert;
      du <= q_dist;
    end
    if (cmd.latch_row) begin
      row <= adj_rdata;
    end
  end

  assign dist_ext = 8'(cur_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit || cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status            <= bfsam_pkg::STATUS_VISITED;
      visited_index     <= 4'(cur);
      visited_label     <= 32'(label_rdata);
      distance          <= (dist_ext > 8'd15) ? 4'd15 : 4'(cur_dist);
      has_predecessor   <= !cur_root;
      predecessor_index <= 4'(cur_pred);
      new_tree          <= cur_root;
      last              <= (count == n);
    end else if (cmd.emit_err) begin
      status            <= bfsam_pkg::STATUS_NOT_FOUND;
      visited_index     <= '0;
      visited_label     <= '0;
      distance          <= '0;
      has_predecessor   <= 1'b0;
      predecessor_index <= '0;
      new_tree          <= 1'b0;
      last              <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  ap_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed the tail");

  ap_queue_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= CW'(MAX_VERTICES))
    else $error("more vertices queued than exist");

  ap_disc_unvisited: assert property (@(posedge clk) disable iff (rst)
    cmd.disc |-> !visited[cur])
    else $error("vertex discovered twice");

  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.disc |-> (count < n))
    else $error("more discoveries than vertices in use");
`endif

endmodule

>>> tb/bfs_adjacency_matrix_walk_tb.sv
// Self-checking testbench for the breadth-first adjacency-matrix walk.
// Depends on bfsam_pkg and bfs_adjacency_matrix_walk; drives items, checks every
// visit transfer against a built-in predictor of the BFS forest.
module bfs_adjacency_matrix_walk_tb;

  localparam int VERTS      = bfsam_pkg::MAX_VERTICES_DEF;
  localparam int STALL_MAX  = 2500;   // cycles with no transfer before giving up
  localparam logic [2:0] COUNT_ADDR = {bfsam_pkg::REG_VERTEX_COUNT, 2'b00};

  // One input item as the sender presents it.
  typedef struct packed {
    logic        action;
    logic [3:0]  vertex_index;
    logic [15:0] adjacency_row;
    logic [31:0] vertex_label;
    logic [31:0] source_label;
  } item_t;

  // One visit transfer, in port order.
  typedef struct packed {
    logic        status;
    logic [3:0]  visited_index;
    logic [31:0] visited_label;
    logic [3:0]  distance;
    logic        has_predecessor;
    logic [3:0]  predecessor_index;
    logic        new_tree;
    logic        last;
  } visit_t;

  typedef enum logic [1:0] {WHITE, GREY, BLACK} shade_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               action = bfsam_pkg::ACT_LOAD;
  logic [3:0]         vertex_index = '0;
  logic [15:0]        adjacency_row = '0;
  logic signed [31:0] vertex_label = '0;
  logic signed [31:0] source_label = '0;
  logic               result_valid;
  logic               status;
  logic [3:0]         visited_index;
  logic signed [31:0] visited_label;
  logic [3:0]         distance;
  logic               has_predecessor;
  logic [3:0]         predecessor_index;
  logic               new_tree;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  bfs_adjacency_matrix_walk DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .action(action), .vertex_index(vertex_index), .adjacency_row(adjacency_row),
    .vertex_label(vertex_label), .source_label(source_label),
    .result_valid(result_valid), .status(status), .visited_index(visited_index),
    .visited_label(visited_label), .distance(distance),
    .has_predecessor(has_predecessor), .predecessor_index(predecessor_index),
    .new_tree(new_tree), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be offered, and visits the block still owes us.
  item_t  pending_items[$];
  visit_t visits_due[$];

  // Mirror of the block's graph memories and its vertex_count register.
  logic [15:0] adj_rows[VERTS];
  logic [31:0] vertex_labels[VERTS];
  logic [4:0]  count_mirror = bfsam_pkg::VERTEX_COUNT_RST;

  // Latest label queued for each vertex; used to aim runs at labels that will
  // be present when the run is taken, and to reload a vertex with its label.
  logic [31:0] loaded_labels[VERTS];

  int  mismatches = 0;
  int  gap_left = 0;
  bit  calm = 1'b0;        // no sender idling in the closing stretch
  item_t held;

  // Work out the whole BFS forest for one run and queue its visits. The search
  // takes the lowest vertex in use whose label matches. After the tree from
  // that source, every vertex still white starts a fresh tree, in index order.
  function automatic void predict_walk(input logic [31:0] want);
    int     live;
    int     src;
    int     root;
    int     u;
    bit     found;
    shade_t shade[VERTS];
    logic [3:0] depth[VERTS];
    int     frontier[$];
    visit_t run_out[$];
    visit_t v;

    live  = (count_mirror > VERTS) ? VERTS : int'(count_mirror);
    found = 1'b0;
    src   = 0;
    for (int i = 0; i < live; i++) begin
      if (!found && vertex_labels[i] == want) begin
        found = 1'b1;
        src = i;
      end
    end

    if (!found) begin
      // A missing label gives a single error transfer with last set and all else zero.
      v = '0;
      v.status = bfsam_pkg::STATUS_NOT_FOUND;
      v.last = 1'b1;
      visits_due.push_back(v);
      return;
    end

    for (int i = 0; i < VERTS; i++) begin
      shade[i] = WHITE;
      depth[i] = '0;
    end

    for (int t = -1; t < live; t++) begin
      root = (t < 0) ? src : t;
      if (shade[root] != WHITE) continue;
      shade[root] = GREY;
      depth[root] = '0;
      v = '0;
      v.status        = bfsam_pkg::STATUS_VISITED;
      v.visited_index = 4'(root);
      v.visited_label = vertex_labels[root];
      v.new_tree      = 1'b1;
      run_out.push_back(v);
      frontier.push_back(root);
      while (frontier.size() > 0) begin
        u = frontier.pop_front();
        // Columns at or above the vertex count are never looked at.
        for (int j = 0; j < live; j++) begin
          if (adj_rows[u][j] && shade[j] == WHITE) begin
            shade[j] = GREY;
            depth[j] = (depth[u] == 4'hF) ? 4'hF : depth[u] + 4'd1;
            v = '0;
            v.status            = bfsam_pkg::STATUS_VISITED;
            v.visited_index     = 4'(j);
            v.visited_label     = vertex_labels[j];
            v.distance          = depth[j];
            v.has_predecessor   = 1'b1;
            v.predecessor_index = 4'(u);
            run_out.push_back(v);
            frontier.push_back(j);
          end
        end
        shade[u] = BLACK;
      end
    end

    run_out[run_out.size() - 1].last = 1'b1;
    foreach (run_out[k]) visits_due.push_back(run_out[k]);
  endfunction

  // Sender. An item transfer happens at an edge with start high and busy low;
  // the accepted item is folded into the mirror or predicted right then. The
  // next item, or a short idle burst, is chosen in the same step so start
  // gets exactly one update per edge.
  always @(posedge clk) begin : sender
    bit offer;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      offer = start;
      if (start && !busy) begin
        if (held.action == bfsam_pkg::ACT_LOAD) begin
          adj_rows[held.vertex_index]      = held.adjacency_row;
          vertex_labels[held.vertex_index] = held.vertex_label;
        end else begin
          predict_walk(held.source_label);
        end
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
          end else begin
            held = pending_items.pop_front();
            action        <= held.action;
            vertex_index  <= held.vertex_index;
            adjacency_row <= held.adjacency_row;
            vertex_label  <= held.vertex_label;
            source_label  <= held.source_label;
            offer = 1'b1;
          end
        end
      end
      start <= offer;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver. It cannot stall, so every strobe is a transfer and is checked
  // against the oldest visit still owed.
  always @(posedge clk) begin : receiver
    visit_t got;
    visit_t exp_v;
    if (!rst && result_valid) begin
      got = {status, visited_index, visited_label, distance, has_predecessor,
             predecessor_index, new_tree, last};
      if (visits_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %0h",
                 $time, got);
        mismatches++;
      end else begin
        exp_v = visits_due.pop_front();
        check_field("status", 32'(exp_v.status), 32'(got.status));
        check_field("visited_index", 32'(exp_v.visited_index), 32'(got.visited_index));
        check_field("visited_label", exp_v.visited_label, got.visited_label);
        check_field("distance", 32'(exp_v.distance), 32'(got.distance));
        check_field("has_predecessor", 32'(exp_v.has_predecessor),
                    32'(got.has_predecessor));
        check_field("predecessor_index", 32'(exp_v.predecessor_index),
                    32'(got.predecessor_index));
        check_field("new_tree", 32'(exp_v.new_tree), 32'(got.new_tree));
        check_field("last", 32'(exp_v.last), 32'(got.last));
      end
    end
  end

  // Watchdog: any item, visit or register transfer resets the count.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (start && !busy) || result_valid || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic void add_load(input logic [3:0] idx, input logic [15:0] row,
                                   input logic [31:0] label);
    item_t it;
    it = '0;
    it.action        = bfsam_pkg::ACT_LOAD;
    it.vertex_index  = idx;
    it.adjacency_row = row;
    it.vertex_label  = label;
    it.source_label  = $urandom;   // ignored by a load, but keep it moving
    pending_items.push_back(it);
    loaded_labels[idx] = label;
  endfunction

  function automatic void add_run(input logic [31:0] label);
    item_t it;
    it = '0;
    it.action        = bfsam_pkg::ACT_RUN;
    it.vertex_index  = 4'($urandom);
    it.adjacency_row = 16'($urandom);
    it.vertex_label  = $urandom;
    it.source_label  = label;
    pending_items.push_back(it);
  endfunction

  // Single-bit and two-bit rows so the forest has depth and several trees, with
  // empty, full and random rows mixed in.
  function automatic logic [15:0] pick_row();
    case ($urandom_range(0, 6))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'(1) << $urandom_range(0, 15);
      4:       return (16'(1) << $urandom_range(0, 15)) | (16'(1) << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // A small pool of labels makes duplicates, which checks lowest-index matching.
  function automatic logic [31:0] pick_label();
    if ($urandom_range(0, 2) == 0) return 32'($urandom_range(0, 10)) - 32'd5;
    return $urandom;
  endfunction

  // Hold off until the block is idle and nothing is owed, then let the result
  // register settle before touching the configuration.
  task automatic wait_idle();
    while (pending_items.size() != 0 || start || busy || visits_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write vertex_count, then read it back through the same port.
  task automatic write_count(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    count_mirror = value[4:0];
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready && prdata !== 32'(count_mirror)) begin
      $display("%0t: vertex_count readback mismatch, expected %0h, actual %0h",
               $time, 32'(count_mirror), prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] lbl;
    logic [31:0] count_plan[8];
    int          live;

    // Directed part. Every vertex is loaded first so no run ever reads an
    // entry that was never written. The rows form one long chain 0..15, so
    // the deepest vertex sits at distance 15; vertex 15 points at everyone.
    for (int i = 0; i < VERTS; i++) begin
      case (i)
        0:       lbl = 32'h8000_0000;
        7:       lbl = 32'h0000_0000;
        8:       lbl = 32'hFFFF_FFFF;
        12:      lbl = 32'h1234_5678;     // same label as vertex 5
        5:       lbl = 32'h1234_5678;
        15:      lbl = 32'h7FFF_FFFF;
        default: lbl = (32'(i) * 32'h1111_1111) ^ 32'h00A5_5A00;
      endcase
      add_load(4'(i), (i == 15) ? 16'hFFFF : 16'(1) << (i + 1), lbl);
    end
    add_run(32'h8000_0000);     // chain from vertex 0, distance climbs to 15
    add_run(32'h7FFF_FFFF);     // full row, everybody at distance 1
    add_run(32'h1234_5678);     // duplicate label, vertex 5 wins
    add_run(32'h5555_5555);     // label absent
    // Break the chain at vertex 9 and empty vertex 15's row so the walk has to restart new trees.
    add_load(4'd9, 16'h0000, loaded_labels[9]);
    add_load(4'd15, 16'h0000, 32'h7FFF_FFFF);
    add_run(32'hFFFF_FFFF);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Random part: several vertex counts, the extremes among them. A count of
    // zero means nothing is in use; 31 is clamped to the full graph.
    count_plan = '{32'd16, 32'd1, 32'd31, 32'd0, 32'($urandom_range(2, 8)),
                   32'($urandom_range(9, 15)), 32'd2, 32'd16};
    foreach (count_plan[p]) begin
      wait_idle();
      write_count(count_plan[p]);
      if (p == 7) calm = 1'b1;
      live = (count_plan[p] > VERTS) ? VERTS : int'(count_plan[p]);
      for (int k = 0; k < 31; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          add_load(4'($urandom_range(0, 15)), pick_row(), pick_label());
        end else if (live > 0 && $urandom_range(0, 3) != 0) begin
          add_run(loaded_labels[$urandom_range(0, live - 1)]);
        end else begin
          add_run(pick_label());
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/bfsam_pkg.sv
src/bfsam_ram.sv
src/bfsam_ctrl.sv
src/bfsam_dp.sv
src/bfs_adjacency_matrix_walk.sv
tb/bfs_adjacency_matrix_walk_tb.sv
